>>> rtl/core/tof_quad_modulation_sequencer_core_assert.svh
// Assertion macros used by the sequencer back end.
`ifndef TOF_QUAD_MODULATION_SEQUENCER_CORE_ASSERT_SVH
`define TOF_QUAD_MODULATION_SEQUENCER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TQMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define TQMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TQMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TQMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/tof_qms_pkg.sv
// Types, constants and helper functions of the modulation sequencer.
`timescale 1ns / 1ps
package tof_qms_pkg;

	localparam int NUM_CH    = 4;
	localparam int CH_W      = 2;
	localparam int NUM_SLOTS = 8;
	localparam int SLOT_W    = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] CMD_BYTE  = 3'd0;
	localparam logic [2:0] CMD_ILLUM = 3'd1;
	localparam logic [2:0] CMD_EXPO  = 3'd2;
	localparam logic [2:0] CMD_FRAME = 3'd3;
	localparam logic [2:0] CMD_START = 3'd4;

	localparam logic KIND_WORDS  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [7:0]  DELIM        = 8'hFF;
	localparam logic [5:0]  COUNT_MAX    = 6'd52;
	localparam logic [5:0]  PACKET_LEN   = 6'd51;
	localparam logic [5:0]  POS_HEAD     = 6'd0;
	localparam logic [5:0]  POS_CHANNEL  = 6'd1;
	localparam logic [5:0]  POS_FREQ     = 6'd2;
	localparam logic [5:0]  POS_PHASE    = 6'd34;
	localparam logic [5:0]  POS_TAIL     = 6'd50;
	localparam logic [31:0] DEFAULT_FREQ = 32'h1999_999A;

	typedef struct packed {
		logic [2:0]      cmd;
		logic            ack;
		logic            wr;
		logic [CH_W-1:0] ch;
	} op_t;

	typedef struct packed {
		logic              strobe;
		logic              kind;
		logic [CH_W-1:0]   channel;
		logic [31:0]       freq_word;
		logic [15:0]       phase_word;
		logic              phase_valid;
		logic              ack;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} res_t;

	// Even channels step the phase by a sixteenth of a turn per slot after reset.
	function automatic logic [15:0] rst_phase(input logic [CH_W-1:0] c,
			input logic [SLOT_W-1:0] s);
		rst_phase = c[0] ? 16'h0000 : {2'b00, s[1:0], 12'h000};
	endfunction

endpackage

>>> rtl/core/tof_qms_fifo.sv
// Short command queue between the front and the back of the sequencer.
`timescale 1ns / 1ps
module tof_qms_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tof_qms_pkg::op_t  din,
	input  logic              pop,
	output tof_qms_pkg::op_t  dout,
	output logic              empty,
	output logic              full
);

	tof_qms_pkg::op_t mem_q [tof_qms_pkg::QUEUE_DEPTH];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'(tof_qms_pkg::QUEUE_DEPTH));
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/core/tof_qms_front.sv
// Front end: takes words, stages host packets and queues events for the back end.
`timescale 1ns / 1ps
module tof_qms_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     cmd,
	input  logic [7:0]                     packet_byte,
	input  logic                           packet_end,
	output logic                           push,
	output tof_qms_pkg::op_t               push_op,
	input  logic                           queue_full,
	input  logic                           commit_done,
	input  logic [tof_qms_pkg::SLOT_W-1:0] stg_idx,
	output logic [31:0]                    stg_freq,
	output logic [15:0]                    stg_phase
);

	logic [5:0] byte_count_q;
	logic       frame_ok_q;
	logic [7:0] staged_ch_q;
	logic       commit_pend_q;
	logic [31:0] stg_freq_q  [tof_qms_pkg::NUM_SLOTS];
	logic [15:0] stg_phase_q [tof_qms_pkg::NUM_SLOTS];

	logic       acc;
	logic       is_byte;
	logic       delim_bad;
	logic       ok_n;
	logic [5:0] cnt_inc;
	logic       pkt_ack;
	logic [5:0] foff;
	logic [5:0] poff;

	// A pending table load reads the staging words, so new words wait for it.
	assign busy    = queue_full || commit_pend_q;
	assign acc     = start && !busy;
	assign is_byte = (cmd == tof_qms_pkg::CMD_BYTE);

	assign delim_bad = ((byte_count_q == tof_qms_pkg::POS_HEAD) ||
			(byte_count_q == tof_qms_pkg::POS_TAIL)) && (packet_byte != tof_qms_pkg::DELIM);
	assign ok_n    = frame_ok_q && !delim_bad;
	assign cnt_inc = (byte_count_q < tof_qms_pkg::COUNT_MAX) ? byte_count_q + 6'd1
			: byte_count_q;
	assign pkt_ack = (cnt_inc == tof_qms_pkg::PACKET_LEN) && ok_n;
	assign foff    = byte_count_q - tof_qms_pkg::POS_FREQ;
	assign poff    = byte_count_q - tof_qms_pkg::POS_PHASE;

	always_comb begin
		push            = 1'b0;
		push_op.cmd     = cmd;
		push_op.ack     = pkt_ack;
		push_op.wr      = pkt_ack && (staged_ch_q < 8'(tof_qms_pkg::NUM_CH));
		push_op.ch      = staged_ch_q[tof_qms_pkg::CH_W-1:0];
		if (acc) begin
			unique case (cmd)
				tof_qms_pkg::CMD_BYTE:  push = packet_end;
				tof_qms_pkg::CMD_ILLUM,
				tof_qms_pkg::CMD_EXPO,
				tof_qms_pkg::CMD_FRAME,
				tof_qms_pkg::CMD_START: push = 1'b1;
				default:                push = 1'b0;
			endcase
		end
	end

	assign stg_freq  = stg_freq_q[stg_idx];
	assign stg_phase = stg_phase_q[stg_idx];

	always_ff @(posedge clk) begin
		if (acc && is_byte) begin
			if (byte_count_q == tof_qms_pkg::POS_CHANNEL) begin
				staged_ch_q <= packet_byte;
			end
			if ((byte_count_q >= tof_qms_pkg::POS_FREQ) &&
					(byte_count_q < tof_qms_pkg::POS_PHASE)) begin
				stg_freq_q[foff[4:2]][{~foff[1:0], 3'b000} +: 8] <= packet_byte;
			end
			if ((byte_count_q >= tof_qms_pkg::POS_PHASE) &&
					(byte_count_q < tof_qms_pkg::POS_TAIL)) begin
				stg_phase_q[poff[3:1]][{~poff[0], 3'b000} +: 8] <= packet_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= 6'd0;
			frame_ok_q    <= 1'b1;
			commit_pend_q <= 1'b0;
		end else begin
			if (acc && is_byte) begin
				if (packet_end) begin
					byte_count_q <= 6'd0;
					frame_ok_q   <= 1'b1;
				end else begin
					byte_count_q <= cnt_inc;
					frame_ok_q   <= ok_n;
				end
			end
			if (push && is_byte && push_op.wr) begin
				commit_pend_q <= 1'b1;
			end else if (commit_done) begin
				commit_pend_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/tof_qms_back.sv
// Back end: runs queued events, owns the slot tables and drives the result register.
`timescale 1ns / 1ps
`include "tof_quad_modulation_sequencer_core_assert.svh"
module tof_qms_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           queue_empty,
	input  tof_qms_pkg::op_t               op,
	output logic                           pop,
	output logic                           commit_done,
	output logic [tof_qms_pkg::SLOT_W-1:0] stg_idx,
	input  logic [31:0]                    stg_freq,
	input  logic [15:0]                    stg_phase,
	output tof_qms_pkg::res_t              res
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_EMIT   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	localparam int CH_W   = tof_qms_pkg::CH_W;
	localparam int SLOT_W = tof_qms_pkg::SLOT_W;

	logic [1:0]        state_q;
	logic [SLOT_W-1:0] idx_q;
	logic              shut_q;
	logic [CH_W-1:0]   ch_q;
	logic [1:0]        quad_q;
	logic              parity_q;
	logic [SLOT_W-1:0] slot_q;
	logic              modulating_q;
	logic [tof_qms_pkg::NUM_CH-1:0] tbl_valid_q;
	logic [31:0] cur_freq_q  [tof_qms_pkg::NUM_CH];
	logic [15:0] cur_phase_q [tof_qms_pkg::NUM_CH];
	logic [31:0] freq_tbl_q  [tof_qms_pkg::NUM_CH][tof_qms_pkg::NUM_SLOTS];
	logic [15:0] phase_tbl_q [tof_qms_pkg::NUM_CH][tof_qms_pkg::NUM_SLOTS];
	tof_qms_pkg::res_t res_q;

	logic [1:0]        quad_n;
	logic [SLOT_W-1:0] slot_n;
	logic              latch;
	logic [CH_W-1:0]   emit_ch;
	logic              emit_last;
	logic              commit_last;

	assign pop     = (state_q == ST_IDLE) && !queue_empty;
	assign stg_idx = idx_q;
	assign res     = res_q;

	// Even frames visit slots 0,5,6,7 and odd frames visit 4,1,2,3.
	assign quad_n = quad_q + 2'd1;
	always_comb begin
		if (parity_q) begin
			slot_n = (quad_n == 2'd0) ? 3'd4 : {1'b0, quad_n};
		end else begin
			slot_n = (quad_n == 2'd0) ? 3'd0 : {1'b1, quad_n};
		end
	end

	assign latch       = pop && (op.cmd == tof_qms_pkg::CMD_EXPO);
	assign emit_ch     = idx_q[CH_W-1:0];
	assign emit_last   = (emit_ch == CH_W'(tof_qms_pkg::NUM_CH - 1));
	assign commit_last = (idx_q == SLOT_W'(tof_qms_pkg::NUM_SLOTS - 1));
	assign commit_done = (state_q == ST_COMMIT) && commit_last;

	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT) begin
			freq_tbl_q[ch_q][idx_q]  <= stg_freq;
			phase_tbl_q[ch_q][idx_q] <= stg_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < tof_qms_pkg::NUM_CH; c++) begin
				cur_freq_q[c]  <= tof_qms_pkg::DEFAULT_FREQ;
				cur_phase_q[c] <= 16'h0000;
			end
		end else if (latch) begin
			for (int c = 0; c < tof_qms_pkg::NUM_CH; c++) begin
				if (tbl_valid_q[c]) begin
					cur_freq_q[c]  <= freq_tbl_q[c][slot_n];
					cur_phase_q[c] <= phase_tbl_q[c][slot_n];
				end else begin
					cur_freq_q[c]  <= tof_qms_pkg::DEFAULT_FREQ;
					cur_phase_q[c] <= tof_qms_pkg::rst_phase(CH_W'(c), slot_n);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			shut_q       <= 1'b0;
			ch_q         <= '0;
			quad_q       <= 2'd0;
			parity_q     <= 1'b0;
			slot_q       <= '0;
			modulating_q <= 1'b0;
			tbl_valid_q  <= '0;
			res_q        <= '0;
		end else begin
			res_q.strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (op.cmd)
							tof_qms_pkg::CMD_ILLUM: begin
								modulating_q <= 1'b1;
								shut_q       <= 1'b0;
								idx_q        <= '0;
								state_q      <= ST_EMIT;
							end
							tof_qms_pkg::CMD_EXPO: begin
								modulating_q <= 1'b0;
								quad_q       <= quad_n;
								slot_q       <= slot_n;
								shut_q       <= 1'b1;
								idx_q        <= '0;
								state_q      <= ST_EMIT;
							end
							tof_qms_pkg::CMD_FRAME: begin
								quad_q   <= 2'd0;
								parity_q <= ~parity_q;
							end
							tof_qms_pkg::CMD_START: begin
								parity_q <= 1'b0;
							end
							tof_qms_pkg::CMD_BYTE: begin
								if (op.ack) begin
									parity_q <= 1'b0;
								end
								if (op.wr) begin
									ch_q    <= op.ch;
									idx_q   <= '0;
									state_q <= ST_COMMIT;
								end else begin
									res_q.strobe      <= 1'b1;
									res_q.kind        <= tof_qms_pkg::KIND_STATUS;
									res_q.channel     <= '0;
									res_q.freq_word   <= 32'd0;
									res_q.phase_word  <= 16'd0;
									res_q.phase_valid <= 1'b0;
									res_q.ack         <= op.ack;
									res_q.slot        <= slot_q;
									res_q.last        <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_EMIT: begin
					res_q.strobe      <= 1'b1;
					res_q.kind        <= tof_qms_pkg::KIND_WORDS;
					res_q.channel     <= emit_ch;
					res_q.freq_word   <= shut_q ? 32'd0 : cur_freq_q[emit_ch];
					res_q.phase_word  <= shut_q ? 16'd0 : cur_phase_q[emit_ch];
					res_q.phase_valid <= ~shut_q;
					res_q.ack         <= 1'b0;
					res_q.slot        <= slot_q;
					res_q.last        <= emit_last;
					idx_q             <= idx_q + SLOT_W'(1);
					if (emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COMMIT: begin
					idx_q <= idx_q + SLOT_W'(1);
					if (commit_last) begin
						tbl_valid_q[ch_q] <= 1'b1;
						res_q.strobe      <= 1'b1;
						res_q.kind        <= tof_qms_pkg::KIND_STATUS;
						res_q.channel     <= '0;
						res_q.freq_word   <= 32'd0;
						res_q.phase_word  <= 16'd0;
						res_q.phase_valid <= 1'b0;
						res_q.ack         <= 1'b1;
						res_q.slot        <= slot_q;
						res_q.last        <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TQMS_ASSERT_IMP(a_words_while_mod, clk, arst_n, res_q.strobe && (res_q.kind == tof_qms_pkg::KIND_WORDS) && res_q.phase_valid, modulating_q, "tuning words sent while not modulating")
	`TQMS_ASSERT_NXT(a_emit_strobes, clk, arst_n, state_q == ST_EMIT, res_q.strobe, "emit cycle produced no word")
	`TQMS_ASSERT_NXT(a_commit_acks, clk, arst_n, commit_done, res_q.strobe && res_q.ack && res_q.last, "table load ended without an ack")

endmodule

>>> rtl/core/tof_quad_modulation_sequencer_core.sv
// Top level of the time-of-flight quad modulation sequencer.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  command  | start, busy            | cmd, packet_byte, packet_end
//  result   | strobe (one cycle)     | kind, channel, freq_word, phase_word,
//           |                        | phase_valid, ack, slot, last
//
// A word is taken when start is high and busy is low. Illumination and exposure
// events give four results on consecutive cycles, a packet end gives one status
// result in the cycle after dequeue, or at the end of a channel table load (one
// slot per cycle from the staging words). Frame tick and start events give no
// result. A two-word queue lets the front take words while the back emits;
// busy is high while the queue is full or a table load is pending.
// Reset is asynchronous and active low; the receiver cannot stall the results.
`timescale 1ns / 1ps
module tof_quad_modulation_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [7:0]  packet_byte,
	input  logic        packet_end,
	output logic        strobe,
	output logic        kind,
	output logic [1:0]  channel,
	output logic [31:0] freq_word,
	output logic [15:0] phase_word,
	output logic        phase_valid,
	output logic        ack,
	output logic [2:0]  slot,
	output logic        last
);

	tof_qms_pkg::op_t  push_op;
	tof_qms_pkg::op_t  head_op;
	tof_qms_pkg::res_t res;
	logic push;
	logic pop;
	logic q_empty;
	logic q_full;
	logic commit_done;
	logic [tof_qms_pkg::SLOT_W-1:0] stg_idx;
	logic [31:0] stg_freq;
	logic [15:0] stg_phase;

	tof_qms_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.packet_byte (packet_byte),
		.packet_end  (packet_end),
		.push        (push),
		.push_op     (push_op),
		.queue_full  (q_full),
		.commit_done (commit_done),
		.stg_idx     (stg_idx),
		.stg_freq    (stg_freq),
		.stg_phase   (stg_phase)
	);

	tof_qms_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_op),
		.pop    (pop),
		.dout   (head_op),
		.empty  (q_empty),
		.full   (q_full)
	);

	tof_qms_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (q_empty),
		.op          (head_op),
		.pop         (pop),
		.commit_done (commit_done),
		.stg_idx     (stg_idx),
		.stg_freq    (stg_freq),
		.stg_phase   (stg_phase),
		.res         (res)
	);

	assign strobe      = res.strobe;
	assign kind        = res.kind;
	assign channel     = res.channel;
	assign freq_word   = res.freq_word;
	assign phase_word  = res.phase_word;
	assign phase_valid = res.phase_valid;
	assign ack         = res.ack;
	assign slot        = res.slot;
	assign last        = res.last;

endmodule
